// ===== hw/rtl/kcl_pkg.sv =====
package kcl_pkg;

   localparam int NIBBLE_W   = 4;
   localparam int KEY_W      = 8;
   localparam int CODE_SLOTS = 6;                      // nibbles held by the code register
   localparam int CODE_W     = CODE_SLOTS * NIBBLE_W;
   localparam int COUNT_W    = 3;
   localparam int NUM_DIGITS = 10;

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [NIBBLE_W-1:0] nibble_type;
   typedef logic [CODE_W-1:0]   code_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam key_type  KEY_ENTER         = 8'hBD;
   localparam key_type  KEY_CLEAR         = 8'h7D;
   localparam code_type STORED_CODE_RESET = 24'h888888;

   // scan codes of digits 0..9 in order
   localparam key_type DIGIT_KEYS [NUM_DIGITS] = '{
      8'hE7, 8'hD7, 8'hB7, 8'h77, 8'hEB, 8'hDB, 8'hBB, 8'h7B, 8'hED, 8'hDD
   };

   // digit plus one for a digit key, zero for anything else
   function automatic nibble_type key_to_value(input key_type key);
      nibble_type value;
      value = '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (key == DIGIT_KEYS[k]) begin
            value = nibble_type'(k + 1);
         end
      end
      return value;
   endfunction

endpackage

// ===== hw/rtl/kcl_if.sv =====
interface kcl_req_if
   import kcl_pkg::*;
();
   logic    valid;
   logic    ready;
   key_type key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);
endinterface

interface kcl_rsp_if
   import kcl_pkg::*;
();
   logic      valid;
   logic      ready;
   code_type  entered_digits;
   count_type entered_count;
   logic      match_flag;
   logic      lamp_lit;

   modport source (output valid, output entered_digits, output entered_count,
                   output match_flag, output lamp_lit, input ready);
   modport sink   (input valid, input entered_digits, input entered_count,
                   input match_flag, input lamp_lit, output ready);
endinterface

interface kcl_csr_if
   import kcl_pkg::*;
();
   logic     valid;
   logic     ready;
   code_type stored_code;

   modport source (output valid, output stored_code, input ready);
   modport sink   (input valid, input stored_code, output ready);
endinterface

// ===== hw/rtl/keypad_code_lock_top.sv =====
// Keypad combination lock.
// req_chan carries one raw keypad scan code per transaction. Digit keys are
// appended to the entry buffer until it holds CODE_LENGTH digits, enter
// compares a full buffer with the stored code, clear blanks the buffer.
// rsp_chan returns exactly one transaction per key: the buffer, the digit
// count, the last comparison result and the lamp, as they stand after the key.
// csr_chan writes the stored code (six nibbles, entry 0 low); it is always
// ready and should only be written while the lock is idle.
// The key is decoded and the state registers, which also form the result
// register, are updated at the accepting edge.
// Throughput is one key per cycle; req_chan.ready is high whenever the result
// register is empty or being taken in the same cycle, so a stalled receiver
// holds the result and stops further keys until it takes it.
// Reset (synchronous) blanks the buffer, clears count, match and lamp, drops
// any pending result and reloads the stored code with 0x888888.
module keypad_code_lock_top
   import kcl_pkg::*;
#(
   parameter int CODE_LENGTH = 6
) (
   input  logic  clock,
   input  logic  reset,
   kcl_req_if.sink   req_chan,
   kcl_rsp_if.source rsp_chan,
   kcl_csr_if.sink   csr_chan
);

   localparam int CntW  = $clog2(CODE_LENGTH + 1);
   localparam int PackN = (CODE_LENGTH < CODE_SLOTS) ? CODE_LENGTH : CODE_SLOTS;

   code_type         stored_code_ff;
   nibble_type       entry_ff [CODE_LENGTH];
   nibble_type       entry_in [CODE_LENGTH];
   logic [CntW-1:0]  count_ff, count_in;
   logic             match_ff, match_in;
   logic             lamp_ff, lamp_in;
   logic             rsp_valid_ff;

   logic             req_take;
   nibble_type       key_value;
   logic             buf_full;
   logic             code_equal;
   code_type         packed_digits;
   logic [CntW+2:0]  count_wide;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign key_value = key_to_value(req_chan.key_code);
   assign buf_full  = (count_ff == CntW'(CODE_LENGTH));

   // entries beyond the register's six nibbles compare against zero
   always_comb begin
      code_equal = 1'b1;
      for (int k = 0; k < CODE_LENGTH; k++) begin
         if (k < CODE_SLOTS) begin
            if (entry_ff[k] != stored_code_ff[(k % CODE_SLOTS)*NIBBLE_W +: NIBBLE_W]) begin
               code_equal = 1'b0;
            end
         end else if (entry_ff[k] != '0) begin
            code_equal = 1'b0;
         end
      end
   end

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      match_in = match_ff;
      lamp_in  = lamp_ff;
      if (key_value != '0) begin
         if (!buf_full) begin
            for (int k = 0; k < CODE_LENGTH; k++) begin
               if (count_ff == CntW'(k)) begin
                  entry_in[k] = key_value;
               end
            end
            count_in = count_ff + CntW'(1);
         end
      end else if (req_chan.key_code == KEY_ENTER) begin
         if (buf_full) begin
            match_in = code_equal;
            lamp_in  = lamp_ff || code_equal;
         end
      end else if (req_chan.key_code == KEY_CLEAR) begin
         for (int k = 0; k < CODE_LENGTH; k++) begin
            entry_in[k] = '0;
         end
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CODE_LENGTH; k++) begin
            entry_ff[k] <= '0;
         end
         count_ff     <= '0;
         match_ff     <= 1'b0;
         lamp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            entry_ff <= entry_in;
            count_ff <= count_in;
            match_ff <= match_in;
            lamp_ff  <= lamp_in;
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_code_ff <= STORED_CODE_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         stored_code_ff <= csr_chan.stored_code;
      end
   end

   // state registers double as the result register: they only move on a
   // transaction, which can only happen once the pending result is taken
   always_comb begin
      packed_digits = '0;
      for (int k = 0; k < PackN; k++) begin
         packed_digits[k*NIBBLE_W +: NIBBLE_W] = entry_ff[k];
      end
   end

   assign count_wide              = {3'b000, count_ff};
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.entered_digits = packed_digits;
   assign rsp_chan.entered_count  = count_wide[COUNT_W-1:0];
   assign rsp_chan.match_flag     = match_ff;
   assign rsp_chan.lamp_lit       = lamp_ff;

   a_lamp_sticky: assert property (@(posedge clock) disable iff (reset)
      lamp_ff |=> lamp_ff)
      else $error("lamp went dark without reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CODE_LENGTH))
      else $error("digit count beyond code length");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_take && req_chan.key_code == KEY_CLEAR |=> count_ff == '0)
      else $error("clear key left digits in the buffer");

   a_match_lights: assert property (@(posedge clock) disable iff (reset)
      req_take && req_chan.key_code == KEY_ENTER && buf_full && code_equal
      |=> match_ff && lamp_ff)
      else $error("matching code did not light the lamp");

endmodule
